FILE: src/bdq_pkg.sv
// Shared command and status codes and the cell control bundle for the bounded deque.
package bdq_pkg;

    localparam int unsigned CMD_W    = 3;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned LEN_W    = 5;

    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RM_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RM_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_KEY   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOKEY = 2'd3;

    // Broadcast to every cell; flags but del_key are gated by full/empty checks.
    typedef struct packed {
        logic                     ins_front;
        logic                     append;
        logic                     rm_back;
        logic                     del_key;
        logic signed [DATA_W-1:0] data;
    } t_cell_ctrl;

endpackage

FILE: src/bdq_cell.sv
// One storage cell of the deque chain: a value, a valid bit and the match/select ripple.
module bdq_cell
    import bdq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_ctrl               i_ctrl,
    input  logic signed [DATA_W-1:0] i_left_value,
    input  logic                     i_left_valid,
    input  logic signed [DATA_W-1:0] i_right_value,
    input  logic                     i_right_valid,
    input  logic                     i_hit,
    input  logic signed [DATA_W-1:0] i_sel,
    output logic                     o_hit,
    output logic signed [DATA_W-1:0] o_sel,
    output logic signed [DATA_W-1:0] o_value,
    output logic                     o_valid
);

    logic signed [DATA_W-1:0] r_value, n_value;
    logic                     r_valid, n_valid;
    logic                     match, take, is_last;

    assign match   = i_ctrl.del_key & r_valid & (r_value == i_ctrl.data);
    assign o_hit   = i_hit | match;
    assign is_last = r_valid & ~i_right_valid;
    // this cell hands out its value: first key match, or the tail on remove-back
    assign take    = (match & ~i_hit) | (i_ctrl.rm_back & is_last);
    assign o_sel   = i_sel | (take ? r_value : '0);

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.ins_front) begin
            n_value = i_left_value;
            n_valid = i_left_valid;
        end else if (i_ctrl.append) begin
            if (~r_valid & i_left_valid) begin
                n_value = i_ctrl.data;
                n_valid = 1'b1;
            end
        end else if (i_ctrl.rm_back) begin
            if (is_last) n_valid = 1'b0;
        end else if (o_hit) begin
            // remove-front or key delete: close the gap from the right
            n_value = i_right_value;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

FILE: src/bounded_deque_with_key_delete.sv
// Top level of the bounded deque with delete-by-key: command decode, cell chain, result register.
//
// Bounded double-ended queue of signed 32-bit values, at most CAPACITY entries,
// front at cell 0. One command is taken per clock whenever start is high; busy
// is always low, so commands may follow each other in consecutive cycles. Each
// command yields one result transfer in the cycle after it is taken:
// o_strobe is high for that single cycle with o_status, o_removed_value and
// o_length (entry count after the command, low 5 bits). The receiver cannot
// stall, so it must capture the result in that cycle. The clock period
// is set by the combinational ripple of the key match and the removed-value
// select through the row of CAPACITY cells. Status: ok, full (insert on a full
// list, no change), empty (any remove on an empty list), key not present (no
// change). Unused command codes do nothing and report ok with the current length.
module bounded_deque_with_key_delete
    import bdq_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [CMD_W-1:0]           i_cmd,
    input  logic signed [DATA_W-1:0]   i_value,
    output logic                       o_strobe,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [DATA_W-1:0]   o_removed_value,
    output logic [LEN_W-1:0]           o_length
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    // cell row wiring; index CAPACITY is the chain end
    logic signed [DATA_W-1:0] cell_value [CAPACITY];
    logic                     cell_valid [CAPACITY];
    logic                     hit_chain  [CAPACITY+1];
    logic signed [DATA_W-1:0] sel_chain  [CAPACITY+1];

    t_cell_ctrl               ctrl;
    logic                     full, empty, key_found;
    logic                     is_ins, is_rm, is_rm_front;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] removed;

    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_strobe;
    logic [STATUS_W-1:0]      r_status;
    logic signed [DATA_W-1:0] r_removed;
    logic [CNT_W+LEN_W-1:0]   len_ext;

    assign busy = 1'b0;

    assign full  = cell_valid[CAPACITY-1];
    assign empty = ~cell_valid[0];

    assign is_ins      = start & ((i_cmd == CMD_INS_FRONT) | (i_cmd == CMD_APPEND));
    assign is_rm_front = start & (i_cmd == CMD_RM_FRONT) & ~empty;

    always_comb begin
        ctrl.ins_front = start & (i_cmd == CMD_INS_FRONT) & ~full;
        ctrl.append    = start & (i_cmd == CMD_APPEND) & ~full;
        ctrl.rm_back   = start & (i_cmd == CMD_RM_BACK) & ~empty;
        ctrl.del_key   = start & (i_cmd == CMD_DEL_KEY);
        ctrl.data      = i_value;
    end

    // remove-front is a shift-left of every cell: seed the hit ripple at the head
    assign hit_chain[0] = is_rm_front;
    assign sel_chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [DATA_W-1:0] left_value, right_value;
            logic                     left_valid, right_valid;

            if (g == 0) begin : g_head
                assign left_value = i_value;
                assign left_valid = 1'b1;
            end else begin : g_mid
                assign left_value = cell_value[g-1];
                assign left_valid = cell_valid[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign right_value = '0;
                assign right_valid = 1'b0;
            end else begin : g_inner
                assign right_value = cell_value[g+1];
                assign right_valid = cell_valid[g+1];
            end

            bdq_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (ctrl),
                .i_left_value  (left_value),
                .i_left_valid  (left_valid),
                .i_right_value (right_value),
                .i_right_valid (right_valid),
                .i_hit         (hit_chain[g]),
                .i_sel         (sel_chain[g]),
                .o_hit         (hit_chain[g+1]),
                .o_sel         (sel_chain[g+1]),
                .o_value       (cell_value[g]),
                .o_valid       (cell_valid[g])
            );
        end
    endgenerate

    // key match is the only contributor to the hit ripple on a key delete
    assign key_found = hit_chain[CAPACITY];

    always_comb begin
        status  = ST_OK;
        removed = '0;
        is_rm   = 1'b0;
        case (i_cmd)
            CMD_INS_FRONT, CMD_APPEND: begin
                if (full) status = ST_FULL;
            end
            CMD_RM_FRONT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    removed = cell_value[0];
                    is_rm   = 1'b1;
                end
            end
            CMD_RM_BACK: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    removed = sel_chain[CAPACITY];
                    is_rm   = 1'b1;
                end
            end
            CMD_DEL_KEY: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else if (!key_found) begin
                    status = ST_NOKEY;
                end else begin
                    removed = sel_chain[CAPACITY];
                    is_rm   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (is_ins && !full) begin
            n_count = r_count + 1'b1;
        end else if (start && is_rm) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= status;
        r_removed <= removed;
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= start;
        end
    end

    assign len_ext         = {{LEN_W{1'b0}}, r_count};
    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_length        = len_ext[LEN_W-1:0];

endmodule
